// ----- hdl/ald_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ald_pkg: shared types for the ladder keypad debouncer
// Key codes, register indexes and the threshold bundle used by the
// classifier and the top level.
// ----------------------------------------------------------------------------
package ald_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned KEY_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [KEY_W-1:0] {
    KC_NONE = 3'd0,
    KC_BACK = 3'd1,
    KC_OK   = 3'd2,
    KC_DOWN = 3'd3,
    KC_UP   = 3'd4
  } key_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACK_LIMIT = 2'd0,
    CFG_OK_LIMIT   = 2'd1,
    CFG_DOWN_LIMIT = 2'd2,
    CFG_UP_LIMIT   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] back_limit;
    logic [SAMPLE_W-1:0] ok_limit;
    logic [SAMPLE_W-1:0] down_limit;
    logic [SAMPLE_W-1:0] up_limit;
  } limits_t;

  localparam logic [SAMPLE_W-1:0] BACK_LIMIT_RST = 10'd100;
  localparam logic [SAMPLE_W-1:0] OK_LIMIT_RST   = 10'd300;
  localparam logic [SAMPLE_W-1:0] DOWN_LIMIT_RST = 10'd500;
  localparam logic [SAMPLE_W-1:0] UP_LIMIT_RST   = 10'd800;

endpackage
`default_nettype wire

// ----- hdl/ald_classify.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ald_classify: sample scaling and threshold classification
// Divides the sample by a fixed divisor through a reciprocal multiply and
// picks the first threshold the scaled reading falls below.
// ----------------------------------------------------------------------------
module ald_classify #(
  parameter int unsigned READING_DIVISOR = 1
) (
  input  wire logic [ald_pkg::SAMPLE_W-1:0] sample,
  input  wire ald_pkg::limits_t              limits,
  output ald_pkg::key_t                      key
);

  // Round-up reciprocal; exact for 10-bit readings and divisors below 1024
  localparam int unsigned SHIFT = 20;
  localparam int unsigned PROD_W = SHIFT + 1 + ald_pkg::SAMPLE_W;
  localparam longint unsigned MULT =
    ((longint'(1) << SHIFT) + READING_DIVISOR - 1) / READING_DIVISOR;
  localparam logic [SHIFT:0] MULT_V = MULT[SHIFT:0];

  logic [PROD_W-1:0]              product;
  logic [ald_pkg::SAMPLE_W-1:0]   scaled;

  assign product = {{(SHIFT + 1){1'b0}}, sample} * {{ald_pkg::SAMPLE_W{1'b0}}, MULT_V};
  assign scaled  = product[SHIFT +: ald_pkg::SAMPLE_W];

  // Thresholds tested in fixed order, first hit wins
  always_comb begin
    if (scaled < limits.back_limit) begin
      key = ald_pkg::KC_BACK;
    end else if (scaled < limits.ok_limit) begin
      key = ald_pkg::KC_OK;
    end else if (scaled < limits.down_limit) begin
      key = ald_pkg::KC_DOWN;
    end else if (scaled < limits.up_limit) begin
      key = ald_pkg::KC_UP;
    end else begin
      key = ald_pkg::KC_NONE;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ald_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ald_cell: one slot of the class history
// Holds one past class, hands it to the next cell on each beat and flags
// whether it matches the newest class.
// ----------------------------------------------------------------------------
module ald_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire ald_pkg::key_t class_in,
  input  wire ald_pkg::key_t newest,
  output ald_pkg::key_t      class_out,
  output logic               match
);

  ald_pkg::key_t class_r;
  ald_pkg::key_t class_nxt;

  assign class_nxt = shift_en ? class_in : class_r;

  // history slot, cleared to the none code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_r <= ald_pkg::KC_NONE;
    end else begin
      class_r <= class_nxt;
    end
  end

  assign class_out = class_r;
  assign match     = (class_r == newest);

endmodule
`default_nettype wire

// ----- hdl/adc_ladder_key_debouncer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adc_ladder_key_debouncer: resistor ladder keypad debouncer
// Classifies converter readings into keys and reports held-key changes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_adc_sample) takes one converter
//   reading per beat. Output channel (out_valid / out_stall / out_event_key /
//   out_event_valid) returns exactly one beat per input beat, held in the output
//   register or the skid slot. event_valid is high when the held key changed;
//   the key is zero otherwise.
//   Throughput is one beat per cycle while in_stall is low: the classifier and
//   the compare across the history cells both settle in the cycle a beat is taken.
//   The output has a result register plus one skid slot, so one more input
//   beat is taken while a result waits; in_stall rises only when both hold
//   results. A stall on the output never drops or repeats a result.
//   Thresholds are written through cfg_wr_en / cfg_index / cfg_data while
//   idle. Synchronous reset restores the default thresholds, clears the
//   history to the none key, clears the held key and empties the output.
// ----------------------------------------------------------------------------
module adc_ladder_key_debouncer #(
  parameter int unsigned WINDOW_DEPTH    = 4,
  parameter int unsigned READING_DIVISOR = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ald_pkg::SAMPLE_W-1:0]  in_adc_sample,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ald_pkg::KEY_W-1:0]          out_event_key,
  output logic                               out_event_valid,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [ald_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ald_pkg::SAMPLE_W-1:0]  cfg_data
);

  localparam int unsigned CELLS = WINDOW_DEPTH - 1;

  ald_pkg::limits_t limits_r;
  ald_pkg::key_t    held_key_r;
  ald_pkg::key_t    held_key_nxt;
  ald_pkg::key_t    new_class;

  logic push;
  logic pop;
  logic window_agree;
  logic changed;

  logic [ald_pkg::KEY_W-1:0] res_key;
  logic                      res_flag;

  logic                      out_valid_r;
  logic [ald_pkg::KEY_W-1:0] out_key_r;
  logic                      out_flag_r;
  logic                      skid_valid_r;
  logic [ald_pkg::KEY_W-1:0] skid_key_r;
  logic                      skid_flag_r;

  assign push     = in_valid && !in_stall;
  assign pop      = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.back_limit <= ald_pkg::BACK_LIMIT_RST;
      limits_r.ok_limit   <= ald_pkg::OK_LIMIT_RST;
      limits_r.down_limit <= ald_pkg::DOWN_LIMIT_RST;
      limits_r.up_limit   <= ald_pkg::UP_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (ald_pkg::cfg_idx_t'(cfg_index))
        ald_pkg::CFG_BACK_LIMIT: limits_r.back_limit <= cfg_data;
        ald_pkg::CFG_OK_LIMIT:   limits_r.ok_limit   <= cfg_data;
        ald_pkg::CFG_DOWN_LIMIT: limits_r.down_limit <= cfg_data;
        ald_pkg::CFG_UP_LIMIT:   limits_r.up_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  ald_classify #(
    .READING_DIVISOR(READING_DIVISOR)
  ) u_classify (
    .sample (in_adc_sample),
    .limits (limits_r),
    .key    (new_class)
  );

  // history chain: cell 0 holds the previous class, the newest is new_class
  generate
    if (CELLS == 0) begin : g_no_cells
      assign window_agree = 1'b1;
    end else begin : g_cells
      ald_pkg::key_t    chain [CELLS+1];
      logic [CELLS-1:0] cell_match;

      assign chain[0] = new_class;

      for (genvar i = 0; i < CELLS; i++) begin : g_cell
        ald_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .shift_en  (push),
          .class_in  (chain[i]),
          .newest    (new_class),
          .class_out (chain[i+1]),
          .match     (cell_match[i])
        );
      end

      assign window_agree = &cell_match;
    end
  endgenerate

  // held key update
  assign changed      = window_agree && (new_class != held_key_r);
  assign held_key_nxt = (push && changed) ? new_class : held_key_r;
  assign res_key      = changed ? new_class : ald_pkg::KC_NONE;
  assign res_flag     = changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_key_r <= ald_pkg::KC_NONE;
    end else begin
      held_key_r <= held_key_nxt;
    end
  end

  // output register plus skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r  <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      out_key_r  <= skid_key_r;
      out_flag_r <= skid_flag_r;
    end else if (push && (pop || !out_valid_r)) begin
      out_key_r  <= res_key;
      out_flag_r <= res_flag;
    end
    if (push && out_valid_r && !pop) begin
      skid_key_r  <= res_key;
      skid_flag_r <= res_flag;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_key   = out_key_r;
  assign out_event_valid = out_flag_r;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output register empty");

  a_quiet_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_flag_r) |-> (out_key_r == ald_pkg::KC_NONE))
    else $error("key reported without change flag");

  a_held_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && changed) |=> (held_key_r == $past(new_class)))
    else $error("held key did not take the new class");

  a_held_steady: assert property (@(posedge clk) disable iff (!rst_n)
    !push |=> $stable(held_key_r))
    else $error("held key moved without an input beat");

endmodule
`default_nettype wire
